FILE: rtl/otd_pkg.sv
package otd_pkg;

  typedef enum logic [2:0] {
    GK_NONE   = 3'd0,
    GK_ORDER  = 3'd1,
    GK_FINISH = 3'd2,
    GK_START  = 3'd3,
    GK_WAIT   = 3'd4
  } grant_kind_t;

  localparam logic [2:0] PH_START        = 3'd0;
  localparam logic [2:0] PH_READY_ORDER  = 3'd2;
  localparam logic [2:0] PH_READY_FINISH = 3'd4;
  localparam logic [2:0] PH_LAST         = 3'd5;
  localparam logic [2:0] PH_CANCEL       = 3'd7;

  localparam logic [1:0] CFG_SLOT_COUNT      = 2'd0;
  localparam logic [1:0] CFG_THREAD_COUNT    = 2'd1;
  localparam logic [1:0] CFG_ITERATION_COUNT = 2'd2;

  localparam logic [4:0]  SLOT_COUNT_RST      = 5'd2;
  localparam logic [3:0]  THREAD_COUNT_RST    = 4'd2;
  localparam logic [31:0] ITERATION_COUNT_RST = 32'd1;

  typedef struct packed {
    logic [4:0]  slot_count;
    logic [3:0]  thread_count;
    logic [31:0] iteration_count;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic [3:0] thread_id;
  } item_t;

  typedef struct packed {
    grant_kind_t grant_kind;
    logic [3:0]  grant_slot;
    logic [31:0] grant_iteration;
    logic        progress_valid;
    logic [31:0] progress_done;
  } result_t;

endpackage

FILE: rtl/otd_cfg.sv
module otd_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output otd_pkg::cfg_t      cfg
);

  otd_pkg::cfg_t cfg_r;
  otd_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        otd_pkg::CFG_SLOT_COUNT:      cfg_nxt.slot_count      = cfg_data[4:0];
        otd_pkg::CFG_THREAD_COUNT:    cfg_nxt.thread_count    = cfg_data[3:0];
        otd_pkg::CFG_ITERATION_COUNT: cfg_nxt.iteration_count = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_count      <= otd_pkg::SLOT_COUNT_RST;
      cfg_r.thread_count    <= otd_pkg::THREAD_COUNT_RST;
      cfg_r.iteration_count <= otd_pkg::ITERATION_COUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/otd_core.sv
module otd_core #(
  parameter int MAX_SLOTS   = 16,
  parameter int MAX_THREADS = 8,
  parameter int ITER_WIDTH  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  otd_pkg::item_t    item,
  input  otd_pkg::cfg_t     cfg,
  output logic              res_valid,
  output otd_pkg::result_t  res
);

  localparam int PW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int HW  = $clog2(MAX_SLOTS + 1);
  localparam int TIW = $clog2(MAX_THREADS);
  localparam int OTW = $clog2(MAX_THREADS + 2);
  localparam logic [HW-1:0]  WAIT_CODE  = HW'(MAX_SLOTS);
  localparam logic [OTW-1:0] ORDER_FREE = OTW'(MAX_THREADS);
  localparam logic [OTW-1:0] BAD_THREAD = OTW'(MAX_THREADS + 1);

  logic [2:0]            phase_r    [MAX_SLOTS];
  logic [2:0]            phase_nxt  [MAX_SLOTS];
  logic [2:0]            phase_a    [MAX_SLOTS];
  logic [HW-1:0]         holding_r  [MAX_THREADS];
  logic [HW-1:0]         holding_nxt[MAX_THREADS];
  logic [ITER_WIDTH-1:0] started_r, started_nxt;
  logic [ITER_WIDTH-1:0] ordered_r, ordered_nxt;
  logic [ITER_WIDTH-1:0] finished_r, finished_nxt;
  logic [PW-1:0]         start_ptr_r, start_ptr_nxt;
  logic [PW-1:0]         order_ptr_r, order_ptr_nxt;
  logic [PW-1:0]         finish_ptr_r, finish_ptr_nxt;
  logic [OTW-1:0]        ordering_r, ordering_nxt;
  logic                  res_valid_r;
  otd_pkg::result_t      res_r, res_nxt;

  logic [ITER_WIDTH-1:0] n;
  logic [7:0]            eff8;
  logic [TIW-1:0]        th_idx;
  logic                  req;
  logic [HW-1:0]         held;
  logic                  adv;
  logic                  release_ord;
  logic [OTW-1:0]        ot_a;
  logic [2:0]            ph_order, ph_finish, ph_start;
  logic [HW-1:0]         grant;
  logic                  slot_grant;
  logic                  any_grant;
  logic [ITER_WIDTH-1:0] iter;

  function automatic logic [2:0] phase_next(input logic [2:0] p);
    if (p == otd_pkg::PH_CANCEL) return otd_pkg::PH_CANCEL;
    if (p >= otd_pkg::PH_LAST) return otd_pkg::PH_START;
    return p + 3'd1;
  endfunction

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p, input logic [7:0] eff);
    logic [7:0] s;
    s = 8'(p) + 8'd1;
    return (s >= eff) ? '0 : PW'(s);
  endfunction

  assign n      = ITER_WIDTH'(cfg.iteration_count);
  assign th_idx = TIW'(item.thread_id);
  assign req    = item_valid && !item.func &&
                  ({4'b0, item.thread_id} < {4'b0, cfg.thread_count}) &&
                  (8'(item.thread_id) < 8'(MAX_THREADS));
  assign held   = holding_r[th_idx];
  assign adv    = req && (held != WAIT_CODE);
  assign release_ord = req && (8'(item.thread_id) == 8'(ordering_r));
  assign ot_a   = release_ord ? ORDER_FREE : ordering_r;

  always_comb begin
    if (cfg.slot_count == 5'd0) begin
      eff8 = 8'd1;
    end else if ({3'b0, cfg.slot_count} > 8'(MAX_SLOTS)) begin
      eff8 = 8'(MAX_SLOTS);
    end else begin
      eff8 = {3'b0, cfg.slot_count};
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      phase_a[k] = (adv && (held == HW'(k))) ? phase_next(phase_r[k]) : phase_r[k];
    end
  end

  assign ph_order  = phase_a[order_ptr_r];
  assign ph_finish = phase_a[finish_ptr_r];
  assign ph_start  = phase_a[start_ptr_r];

  always_comb begin
    started_nxt    = started_r;
    ordered_nxt    = ordered_r;
    finished_nxt   = finished_r;
    start_ptr_nxt  = start_ptr_r;
    order_ptr_nxt  = order_ptr_r;
    finish_ptr_nxt = finish_ptr_r;
    ordering_nxt   = ordering_r;
    phase_nxt      = phase_r;
    holding_nxt    = holding_r;
    grant          = WAIT_CODE;
    slot_grant     = 1'b0;
    any_grant      = 1'b1;
    iter           = '0;
    res_nxt        = '0;
    res_nxt.grant_kind = otd_pkg::GK_NONE;

    if (item_valid && item.func) begin
      started_nxt  = n;
      finished_nxt = n;
      ordering_nxt = BAD_THREAD;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        if (order_ptr_r == PW'(k)) begin
          phase_nxt[k] = otd_pkg::PH_CANCEL;
        end
      end
    end else if (req) begin
      ordering_nxt = ot_a;
      priority if (ot_a == ORDER_FREE && ordered_r < n &&
                   ph_order == otd_pkg::PH_READY_ORDER) begin
        res_nxt.grant_kind = otd_pkg::GK_ORDER;
        grant         = HW'(order_ptr_r);
        slot_grant    = 1'b1;
        iter          = ordered_r;
        ordered_nxt   = ordered_r + ITER_WIDTH'(1);
        order_ptr_nxt = ptr_next(order_ptr_r, eff8);
        ordering_nxt  = OTW'(item.thread_id);
      end else if (finished_r < n && ph_finish == otd_pkg::PH_READY_FINISH) begin
        res_nxt.grant_kind = otd_pkg::GK_FINISH;
        grant          = HW'(finish_ptr_r);
        slot_grant     = 1'b1;
        iter           = finished_r;
        finished_nxt   = finished_r + ITER_WIDTH'(1);
        finish_ptr_nxt = ptr_next(finish_ptr_r, eff8);
      end else if (started_r < n && ph_start == otd_pkg::PH_START) begin
        res_nxt.grant_kind = otd_pkg::GK_START;
        grant         = HW'(start_ptr_r);
        slot_grant    = 1'b1;
        iter          = started_r;
        started_nxt   = started_r + ITER_WIDTH'(1);
        start_ptr_nxt = ptr_next(start_ptr_r, eff8);
      end else if (finished_r < n) begin
        res_nxt.grant_kind = otd_pkg::GK_WAIT;
      end else begin
        any_grant = 1'b0;
      end

      for (int k = 0; k < MAX_SLOTS; k++) begin
        phase_nxt[k] = (slot_grant && (grant == HW'(k))) ? phase_a[k] + 3'd1 : phase_a[k];
      end
      for (int j = 0; j < MAX_THREADS; j++) begin
        if (any_grant && (th_idx == TIW'(j))) begin
          holding_nxt[j] = grant;
        end
      end

      res_nxt.grant_slot      = slot_grant ? 4'(grant) : 4'd0;
      res_nxt.grant_iteration = 32'(iter);
      res_nxt.progress_valid  = release_ord;
      res_nxt.progress_done   = release_ord ? 32'(ordered_r) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_SLOTS; k++) begin
        phase_r[k] <= otd_pkg::PH_START;
      end
      for (int j = 0; j < MAX_THREADS; j++) begin
        holding_r[j] <= WAIT_CODE;
      end
      started_r    <= '0;
      ordered_r    <= '0;
      finished_r   <= '0;
      start_ptr_r  <= '0;
      order_ptr_r  <= '0;
      finish_ptr_r <= '0;
      ordering_r   <= ORDER_FREE;
      res_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      holding_r    <= holding_nxt;
      started_r    <= started_nxt;
      ordered_r    <= ordered_nxt;
      finished_r   <= finished_nxt;
      start_ptr_r  <= start_ptr_nxt;
      order_ptr_r  <= order_ptr_nxt;
      finish_ptr_r <= finish_ptr_nxt;
      ordering_r   <= ordering_nxt;
      res_valid_r  <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

FILE: rtl/ordered_three_phase_task_dispatcher.sv
// Ordered loop dispatcher. A command is taken on every cycle in which start
// is high; busy is always low, so one command can follow another in each
// cycle. Each command yields exactly one result on the out_ ports, shown for
// one cycle with out_valid high; the command first sits in the input
// register and then passes through the grant logic into the result
// register. The receiver cannot stall, so results must be taken as they
// appear. All slot and thread state sits in flip-flops and is ready right
// after reset. Configuration writes are taken in any cycle and should be
// made only while no command is in flight.
module ordered_three_phase_task_dispatcher #(
  parameter int MAX_SLOTS   = 16,
  parameter int MAX_THREADS = 8,
  parameter int ITER_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [3:0]  in_thread_id,
  output logic        out_valid,
  output logic [2:0]  out_grant_kind,
  output logic [3:0]  out_grant_slot,
  output logic [31:0] out_grant_iteration,
  output logic        out_progress_valid,
  output logic [31:0] out_progress_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  otd_pkg::cfg_t    cfg;
  otd_pkg::item_t   item_r, item_nxt;
  logic             item_valid_r;
  otd_pkg::result_t res;
  logic             res_valid;

  assign busy = 1'b0;

  assign item_nxt.func      = in_func;
  assign item_nxt.thread_id = in_thread_id;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= item_nxt;
    end
  end

  otd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  otd_core #(
    .MAX_SLOTS   (MAX_SLOTS),
    .MAX_THREADS (MAX_THREADS),
    .ITER_WIDTH  (ITER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid_r),
    .item       (item_r),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_valid           = res_valid;
  assign out_grant_kind      = res.grant_kind;
  assign out_grant_slot      = res.grant_slot;
  assign out_grant_iteration = res.grant_iteration;
  assign out_progress_valid  = res.progress_valid;
  assign out_progress_done   = res.progress_done;

`ifndef NO_ASSERTIONS
  a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("transfer produced no result two cycles later");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching transfer");

  a_idle_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_grant_kind == otd_pkg::GK_NONE ||
                   out_grant_kind == otd_pkg::GK_WAIT))
    |-> (out_grant_slot == 4'd0 && out_grant_iteration == 32'd0))
    else $error("slot or iteration set on a grant without a slot");
`endif

endmodule

FILE: tb/otd_grant_checker.sv
`timescale 1ns / 100ps

module otd_grant_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_func,
  input  logic [3:0]  in_thread_id,
  input  logic        out_valid,
  input  logic [2:0]  out_grant_kind,
  input  logic [3:0]  out_grant_slot,
  input  logic [31:0] out_grant_iteration,
  input  logic        out_progress_valid,
  input  logic [31:0] out_progress_done,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  localparam logic [4:0] HOLD_WAIT  = 5'd16;
  localparam logic [3:0] ORDER_FREE = 4'd8;
  localparam logic [3:0] BAD_THREAD = 4'd9;

  logic [4:0]  slot_cfg;
  logic [3:0]  thread_cfg;
  logic [31:0] iter_cfg;

  logic [2:0]  phase_of [16];
  logic [4:0]  holding [8];
  logic [31:0] started_n;
  logic [31:0] ordered_n;
  logic [31:0] finished_n;
  logic [3:0]  start_p;
  logic [3:0]  order_p;
  logic [3:0]  finish_p;
  logic [3:0]  orderer;

  otd_pkg::result_t grant_q [$];
  int               errors = 0;

  function automatic logic [2:0] advance_phase(input logic [2:0] p);
    if (p == otd_pkg::PH_CANCEL) return otd_pkg::PH_CANCEL;
    if (p >= otd_pkg::PH_LAST) return otd_pkg::PH_START;
    return p + 3'd1;
  endfunction

  function automatic logic [3:0] ring_next(input logic [3:0] p);
    int slots;
    int n;
    slots = (slot_cfg == 5'd0) ? 1 : ((slot_cfg > 5'd16) ? 16 : int'(slot_cfg));
    n = int'(p) + 1;
    if (n >= slots) n = 0;
    return n[3:0];
  endfunction

  task automatic clear_model();
    slot_cfg   = otd_pkg::SLOT_COUNT_RST;
    thread_cfg = otd_pkg::THREAD_COUNT_RST;
    iter_cfg   = otd_pkg::ITERATION_COUNT_RST;
    for (int k = 0; k < 16; k++) phase_of[k] = otd_pkg::PH_START;
    for (int k = 0; k < 8; k++) holding[k] = HOLD_WAIT;
    started_n  = '0;
    ordered_n  = '0;
    finished_n = '0;
    start_p    = '0;
    order_p    = '0;
    finish_p   = '0;
    orderer    = ORDER_FREE;
  endtask

  task automatic dispatch_request(input logic func, input logic [3:0] tid,
                                  output otd_pkg::result_t r);
    int         nthr;
    logic [4:0] held;
    logic [4:0] grant;
    bit         granted;
    r = '0;
    nthr = (thread_cfg < 4'd8) ? int'(thread_cfg) : 8;
    if (func) begin
      started_n = iter_cfg;
      finished_n = iter_cfg;
      orderer = BAD_THREAD;
      phase_of[order_p] = otd_pkg::PH_CANCEL;
    end else if (int'(tid) < nthr) begin
      held = holding[tid[2:0]];
      grant = HOLD_WAIT;
      granted = 1'b1;
      if (held < HOLD_WAIT) phase_of[held[3:0]] = advance_phase(phase_of[held[3:0]]);
      if (tid == orderer) begin
        orderer = ORDER_FREE;
        r.progress_valid = 1'b1;
        r.progress_done = ordered_n;
      end
      if (orderer == ORDER_FREE && ordered_n < iter_cfg &&
          phase_of[order_p] == otd_pkg::PH_READY_ORDER) begin
        orderer = tid;
        grant = {1'b0, order_p};
        r.grant_kind = otd_pkg::GK_ORDER;
        r.grant_slot = order_p;
        r.grant_iteration = ordered_n;
        phase_of[order_p] = phase_of[order_p] + 3'd1;
        ordered_n = ordered_n + 32'd1;
        order_p = ring_next(order_p);
      end else if (finished_n < iter_cfg &&
                   phase_of[finish_p] == otd_pkg::PH_READY_FINISH) begin
        grant = {1'b0, finish_p};
        r.grant_kind = otd_pkg::GK_FINISH;
        r.grant_slot = finish_p;
        r.grant_iteration = finished_n;
        phase_of[finish_p] = phase_of[finish_p] + 3'd1;
        finished_n = finished_n + 32'd1;
        finish_p = ring_next(finish_p);
      end else if (started_n < iter_cfg && phase_of[start_p] == otd_pkg::PH_START) begin
        grant = {1'b0, start_p};
        r.grant_kind = otd_pkg::GK_START;
        r.grant_slot = start_p;
        r.grant_iteration = started_n;
        phase_of[start_p] = phase_of[start_p] + 3'd1;
        started_n = started_n + 32'd1;
        start_p = ring_next(start_p);
      end else if (finished_n < iter_cfg) begin
        r.grant_kind = otd_pkg::GK_WAIT;
      end else begin
        granted = 1'b0;
      end
      if (granted) holding[tid[2:0]] = grant;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    otd_pkg::result_t want;
    if (!rst_n) begin
      clear_model();
      grant_q.delete();
    end else begin
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          $error("result transfer with no grant expected");
          errors++;
        end else begin
          want = grant_q.pop_front();
          check_field("grant_kind", 32'(want.grant_kind), 32'(out_grant_kind));
          check_field("grant_slot", 32'(want.grant_slot), 32'(out_grant_slot));
          check_field("grant_iteration", want.grant_iteration, out_grant_iteration);
          check_field("progress_valid", 32'(want.progress_valid), 32'(out_progress_valid));
          check_field("progress_done", want.progress_done, out_progress_done);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          otd_pkg::CFG_SLOT_COUNT:      slot_cfg = cfg_data[4:0];
          otd_pkg::CFG_THREAD_COUNT:    thread_cfg = cfg_data[3:0];
          otd_pkg::CFG_ITERATION_COUNT: iter_cfg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        dispatch_request(in_func, in_thread_id, want);
        grant_q.push_back(want);
      end
    end
    pending <= grant_q.size();
    fail_count <= errors;
  end

endmodule

FILE: tb/tb_ordered_three_phase_task_dispatcher.sv
`timescale 1ns / 100ps

module tb_ordered_three_phase_task_dispatcher;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [3:0]  in_thread_id = '0;
  logic        out_valid;
  logic [2:0]  out_grant_kind;
  logic [3:0]  out_grant_slot;
  logic [31:0] out_grant_iteration;
  logic        out_progress_valid;
  logic [31:0] out_progress_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;

  always #5 clk = ~clk;

  ordered_three_phase_task_dispatcher u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_thread_id        (in_thread_id),
    .out_valid           (out_valid),
    .out_grant_kind      (out_grant_kind),
    .out_grant_slot      (out_grant_slot),
    .out_grant_iteration (out_grant_iteration),
    .out_progress_valid  (out_progress_valid),
    .out_progress_done   (out_progress_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  otd_grant_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_thread_id        (in_thread_id),
    .out_valid           (out_valid),
    .out_grant_kind      (out_grant_kind),
    .out_grant_slot      (out_grant_slot),
    .out_grant_iteration (out_grant_iteration),
    .out_progress_valid  (out_progress_valid),
    .out_progress_done   (out_progress_done),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ordered_three_phase_task_dispatcher: mismatch");
      $finish;
    end
  end

  task automatic issue(input logic f, input logic [3:0] tid);
    int gap;
    start <= 1'b1;
    in_func <= f;
    in_thread_id <= tid;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic reconfigure(input logic [4:0] slots, input logic [3:0] threads,
                             input logic [31:0] iters);
    wait_idle();
    write_reg(otd_pkg::CFG_SLOT_COUNT, 32'(slots));
    write_reg(otd_pkg::CFG_THREAD_COUNT, 32'(threads));
    write_reg(otd_pkg::CFG_ITERATION_COUNT, iters);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [4:0] slots, input logic [3:0] threads,
                           input logic [31:0] iters, input int quota,
                           input int abort_odds, input bit steady);
    int         nthr;
    int         taken;
    logic       f;
    logic [3:0] tid;
    reconfigure(slots, threads, iters);
    nthr = (threads < 4'd8) ? int'(threads) : 8;
    no_gaps = steady;
    taken = 0;
    while (taken < quota) begin
      f = (abort_odds > 0) && ($urandom_range(0, abort_odds - 1) == 0);
      if ($urandom_range(0, 9) != 0) tid = 4'($urandom_range(0, nthr - 1));
      else tid = 4'($urandom_range(0, 15));
      issue(f, tid);
      if (f || int'(tid) < nthr) taken++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // One iteration walked through start, order, finish with two threads.
    issue(1'b0, 4'd0);
    issue(1'b0, 4'd1);
    issue(1'b0, 4'd0);
    issue(1'b0, 4'd1);
    issue(1'b0, 4'd0);
    issue(1'b0, 4'd0);
    issue(1'b0, 4'd1);
    issue(1'b0, 4'd2);
    issue(1'b0, 4'd15);

    // A slot count of zero behaves as a single slot; thread count clamps to eight.
    reconfigure(5'd0, 4'd15, 32'hFFFF_FFFF);
    for (int t = 0; t < 16; t++) issue(1'b0, 4'(t));

    // No thread is allowed at all, and the slot count clamps to the maximum.
    reconfigure(5'd31, 4'd0, 32'hFFFF_FFFF);
    issue(1'b0, 4'd0);
    issue(1'b0, 4'd7);

    run_phase(5'd1, 4'd2, 32'hFFFF_FFFF, 90, 0, 1'b0);
    run_phase(5'd16, 4'd8, 32'hFFFF_FFFF, 120, 0, 1'b1);
    run_phase(5'd5, 4'd3, 32'hFFFF_FFFF, 100, 0, 1'b0);
    run_phase(5'd3, 4'd8, 32'd60, 30, 0, 1'b0);
    for (int k = 0; k < 4; k++) begin
      run_phase(5'($urandom_range(1, 16)), 4'($urandom_range(2, 8)), 32'hFFFF_FFFF,
                90, 0, 1'($urandom_range(0, 3) == 0));
    end
    run_phase(5'd2, 4'd8, 32'd1, 20, 0, 1'b0);
    run_phase(5'd7, 4'd4, 32'hFFFF_FFFF, 100, 60, 1'b0);
    issue(1'b1, 4'($urandom_range(0, 15)));
    issue(1'b0, 4'd0);
    issue(1'b0, 4'd1);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_three_phase_task_dispatcher: match");
    end else begin
      $display("ordered_three_phase_task_dispatcher: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/otd_pkg.sv
rtl/otd_cfg.sv
rtl/otd_core.sv
rtl/ordered_three_phase_task_dispatcher.sv
tb/otd_grant_checker.sv
tb/tb_ordered_three_phase_task_dispatcher.sv
